@@ rtl/kvt_pkg.sv @@
// kvt_pkg: shared sizes, operation and status codes, and the types that pass
// along the cell chain of the key/data table
// no dependencies
package kvt_pkg;

    localparam int ENTRIES   = 16;
    localparam int DATA_BITS = 32;
    localparam int KEY_W     = 32;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_SET    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_PRESENT   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // query item as it walks the chain, collecting hit and free-slot info
    typedef struct packed {
        logic                 active;
        func_t                func;
        logic [KEY_W-1:0]     key;
        logic [DATA_BITS-1:0] data;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [DATA_BITS-1:0] hit_data;
        logic                 free_ok;
        logic [IDX_W-1:0]     free_idx;
    } token_t;

    // write-back broadcast to all cells
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic                 set_valid;
        logic                 clr_valid;
        logic                 load_key;
        logic                 load_data;
        logic [KEY_W-1:0]     key;
        logic [DATA_BITS-1:0] data;
    } wr_cmd_t;

    function automatic logic [DATA_BITS-1:0] to_data(input logic [WORD_W-1:0] d);
        logic [63:0] w;
        w = {32'b0, d};
        return w[DATA_BITS-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input logic [DATA_BITS-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/kvt_cell.sv @@
// kvt_cell: one slot of the key/data table plus one stage of the query chain
// depends on kvt_pkg
module kvt_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [kvt_pkg::IDX_W-1:0] idx,
    input  kvt_pkg::token_t          tok_in,
    output kvt_pkg::token_t          tok_out,
    input  kvt_pkg::wr_cmd_t         wr
);

    logic                          valid_reg;
    logic [kvt_pkg::KEY_W-1:0]     key_reg;
    logic [kvt_pkg::DATA_BITS-1:0] data_reg;
    kvt_pkg::token_t               tok_reg;
    kvt_pkg::token_t               tok_next;
    logic                          match;
    logic                          wr_hit;

    always_comb begin
        tok_next = tok_in;
        match    = tok_in.active && valid_reg && (key_reg == tok_in.key);
        if (match && !tok_in.hit) begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = idx;
            tok_next.hit_data = data_reg;
        end
        // lowest free slot wins
        if (tok_in.active && !valid_reg && !tok_in.free_ok) begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = idx;
        end
    end

    assign wr_hit  = wr.en && (wr.idx == idx);
    assign tok_out = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_hit && wr.set_valid) begin
                valid_reg <= 1'b1;
            end else if (wr_hit && wr.clr_valid) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit && wr.load_key) begin
            key_reg <= wr.key;
        end
        if (wr_hit && wr.load_data) begin
            data_reg <= wr.data;
        end
    end

endmodule

@@ rtl/key_value_table.sv @@
// key_value_table: associative key/data table built as a chain of slot cells
// the query walks the cell chain one slot per cycle; as it leaves the last cell
// the slot is written back and the result registered (or parked if the output
// is busy); a new item is taken only after the last result reached the output
// reset: aresetn synchronous active low, clears all slot valid marks at once
// depends on kvt_pkg and kvt_cell
module key_value_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic signed [31:0] s_key,
    input  logic [31:0] s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [31:0] m_data_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;

    // result output register and a one-deep holding stage behind it
    logic                       m_valid_reg;
    kvt_pkg::status_t           m_status_reg;
    logic                       m_found_reg;
    logic [kvt_pkg::WORD_W-1:0] m_data_reg;
    kvt_pkg::status_t           pend_status_reg;
    logic                       pend_found_reg;
    logic [kvt_pkg::WORD_W-1:0] pend_data_reg;

    kvt_pkg::token_t  chain [kvt_pkg::ENTRIES+1];
    kvt_pkg::token_t  tail;
    kvt_pkg::wr_cmd_t wr;
    kvt_pkg::status_t res_status;
    logic [kvt_pkg::WORD_W-1:0] res_data;
    logic             s_accept;
    logic             out_free;
    logic             res_load;
    logic [kvt_pkg::ENTRIES-1:0] tok_active;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // a result moves into the output register this cycle
    assign res_load = ((state_reg == ST_SCAN) && tail.active && out_free)
                   || ((state_reg == ST_HOLD) && out_free);

    // new query enters the head of the chain with empty search results
    always_comb begin
        chain[0]          = '0;
        chain[0].active   = s_accept;
        chain[0].func     = kvt_pkg::func_t'(s_func);
        chain[0].key      = $unsigned(s_key);
        chain[0].data     = kvt_pkg::to_data(s_data_in);
    end

    for (genvar i = 0; i < kvt_pkg::ENTRIES; i++) begin : g_cell
        kvt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx     (kvt_pkg::IDX_W'(i)),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .wr      (wr)
        );
        assign tok_active[i] = chain[i+1].active;
    end

    assign tail = chain[kvt_pkg::ENTRIES];

    // decide the operation outcome once the query leaves the last cell
    always_comb begin
        wr         = '0;
        wr.key     = tail.key;
        wr.data    = tail.data;
        res_status = kvt_pkg::STAT_OK;
        res_data   = '0;
        unique case (tail.func)
            kvt_pkg::FUNC_INSERT: begin
                wr.idx = tail.free_idx;
                if (tail.hit) begin
                    res_status = kvt_pkg::STAT_PRESENT;
                end else if (!tail.free_ok) begin
                    res_status = kvt_pkg::STAT_FULL;
                end else begin
                    wr.en        = tail.active;
                    wr.set_valid = 1'b1;
                    wr.load_key  = 1'b1;
                    wr.load_data = 1'b1;
                end
            end
            kvt_pkg::FUNC_DELETE: begin
                wr.idx       = tail.hit_idx;
                wr.en        = tail.active && tail.hit;
                wr.clr_valid = 1'b1;
                if (!tail.hit) res_status = kvt_pkg::STAT_NOT_FOUND;
            end
            kvt_pkg::FUNC_GET: begin
                wr.idx = tail.hit_idx;
                if (tail.hit) begin
                    res_data = kvt_pkg::to_word(tail.hit_data);
                end else begin
                    res_status = kvt_pkg::STAT_NOT_FOUND;
                end
            end
            kvt_pkg::FUNC_SET: begin
                wr.idx       = tail.hit_idx;
                wr.en        = tail.active && tail.hit;
                wr.load_data = 1'b1;
                if (!tail.hit) res_status = kvt_pkg::STAT_NOT_FOUND;
            end
            default: begin
                wr.idx = tail.hit_idx;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (tail.active) begin
                        if (out_free) begin
                            m_status_reg <= res_status;
                            m_found_reg  <= tail.hit;
                            m_data_reg   <= res_data;
                            state_reg    <= ST_IDLE;
                        end else begin
                            // output still busy: park the result
                            pend_status_reg <= res_status;
                            pend_found_reg  <= tail.hit;
                            pend_data_reg   <= res_data;
                            state_reg       <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_status_reg <= pend_status_reg;
                        m_found_reg  <= pend_found_reg;
                        m_data_reg   <= pend_data_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_found    = m_found_reg;
    assign m_data_out = m_data_reg;

    // only one query may be in the chain at a time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_active))
        else $error("more than one query in the cell chain");

    // the query leaves the chain only while the controller is scanning
    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.active |-> (state_reg == ST_SCAN))
        else $error("query left the chain outside a scan");

    // an accepted item enters the first cell on the next cycle
    a_enter_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> chain[1].active)
        else $error("accepted item did not enter the chain");

    // a parked result only exists while the output register is occupied
    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_valid_reg)
        else $error("result parked while output register was free");

endmodule
